@@ hdl/fixed_block_allocator_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Fixed block allocator unit - assertion macros
// Shared macros for concurrent assertions in the checker file.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Assertion that is off while reset is asserted
`define FBA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that also covers the reset cycles
`define FBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/fba_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed block allocator package
// Field widths, opcode and status codes, and the result bundle.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    // Opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 2'd1;

    // Reset values of the configuration registers
    localparam logic [ADDR_W-1:0] FIRST_ADDRESS_RST = 48'd0;
    localparam logic [SIZE_W-1:0] BLOCK_BYTES_RST   = 32'd4096;

    // Finished request handed from the walker to the output stage
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   block_address;
    } fba_result_t;

endpackage

@@ hdl/fba_flag_ram.sv @@
// ----------------------------------------------------------------------------
// Used-flag memory
// One bit per block, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fba_flag_ram #(
    parameter int BLOCK_COUNT = 64,
    parameter int IDX_W       = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic             wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic             rd_data
);

    logic mem [BLOCK_COUNT];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered data
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/fba_walker.sv @@
// ----------------------------------------------------------------------------
// Block walker
// Clears the flag memory after reset, then serves one request at a time by
// stepping through blocks 1..BLOCK_COUNT-1, one flag read per cycle.
// ----------------------------------------------------------------------------
module fba_walker
    import fba_pkg::*;
#(
    parameter int BLOCK_COUNT = 64,
    parameter int IDX_W       = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    // request side
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_op,
    input  logic [SIZE_W-1:0] in_req,
    input  logic [ADDR_W-1:0] in_addr,
    // configuration
    input  logic [ADDR_W-1:0] first_address,
    input  logic [SIZE_W-1:0] block_bytes,
    // result side
    input  logic              out_free,
    output fba_result_t       res,
    // flag memory
    output logic              ram_wr_en,
    output logic [IDX_W-1:0]  ram_wr_addr,
    output logic              ram_wr_data,
    output logic [IDX_W-1:0]  ram_rd_addr,
    input  logic              ram_rd_data
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(BLOCK_COUNT - 1);

    logic [1:0]          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic                op_reg;
    logic                fit_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                hit;
    logic                accept;

    assign accept = in_valid && in_ready;

    // Match test for the entry whose flag arrives this cycle
    assign hit = (op_reg == OP_FREE) ? (base_reg == addr_reg) : (fit_reg && !ram_rd_data);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        base_next     = base_reg;
        status_next   = status_reg;
        res_addr_next = res_addr_reg;
        in_ready      = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = idx_reg;
        ram_wr_data   = 1'b0;
        ram_rd_addr   = idx_reg + IDX_FIRST;
        res           = '0;
        case (state_reg)
            S_CLEAR: begin
                ram_wr_en = 1'b1;
                idx_next  = idx_reg + IDX_FIRST;
                if (idx_reg == IDX_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready    = 1'b1;
                ram_rd_addr = IDX_FIRST;
                if (in_valid) begin
                    idx_next   = IDX_FIRST;
                    base_next  = first_address + {{(ADDR_W-SIZE_W){1'b0}}, block_bytes};
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (hit) begin
                    ram_wr_en     = 1'b1;
                    ram_wr_data   = (op_reg == OP_ALLOC);
                    status_next   = ST_OK;
                    res_addr_next = (op_reg == OP_ALLOC) ? base_reg : '0;
                    state_next    = S_DONE;
                end else if (idx_reg == IDX_LAST) begin
                    status_next   = (op_reg == OP_ALLOC) ? ST_NO_BLOCK : ST_NO_MATCH;
                    res_addr_next = '0;
                    state_next    = S_DONE;
                end else begin
                    idx_next  = idx_reg + IDX_FIRST;
                    base_next = base_reg + {{(ADDR_W-SIZE_W){1'b0}}, block_bytes};
                end
            end
            S_DONE: begin
                if (out_free) begin
                    res.valid         = 1'b1;
                    res.status        = status_reg;
                    res.block_address = res_addr_reg;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Request and result payload
    always_ff @(posedge aclk) begin
        base_reg     <= base_next;
        status_reg   <= status_next;
        res_addr_reg <= res_addr_next;
        if (accept) begin
            op_reg   <= in_op;
            fit_reg  <= (block_bytes >= in_req);
            addr_reg <= in_addr;
        end
    end

endmodule

@@ hdl/fixed_block_allocator_unit.sv @@
// Operation: a request is taken, the walker steps through blocks 1..BLOCK_COUNT-1
// until it settles at a block, then waits until the output register is free.
// One request is in progress at a time; no new request is taken during the walk.
// The next request is taken as soon as the result is in the output register.
// Reset: synchronous, active low; afterwards a clearing pass over all BLOCK_COUNT blocks
// zeroes the flag memory while s_tready stays low. Config writes are taken outside reset.
// ----------------------------------------------------------------------------
// Fixed block allocator unit
// First-fit allocator over a pool of equal-sized blocks, with stream ports
// for requests and results and a plain write port for configuration.
// ----------------------------------------------------------------------------
module fixed_block_allocator_unit
    import fba_pkg::*;
#(
    parameter int BLOCK_COUNT = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [79:0]          s_tdata,   // [31:0] request_size, [79:32] address
    input  logic                 s_tuser,   // [0] opcode
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ADDR_W-1:0]    m_tdata,   // [47:0] block_address
    output logic [STATUS_W-1:0]  m_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(BLOCK_COUNT);

    logic [ADDR_W-1:0]   first_address_reg;
    logic [SIZE_W-1:0]   block_bytes_reg;
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ADDR_W-1:0]   m_addr_reg;
    logic                out_free;
    fba_result_t         res;
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic                ram_wr_data;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic                ram_rd_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_address_reg <= FIRST_ADDRESS_RST;
            block_bytes_reg   <= BLOCK_BYTES_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_FIRST_ADDRESS: first_address_reg <= cfg_wdata;
                CFG_BLOCK_BYTES:   block_bytes_reg   <= cfg_wdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Output register: free when empty or being taken
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_status_reg <= res.status;
            m_addr_reg   <= res.block_address;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_addr_reg;

    fba_walker #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .IDX_W       (IDX_W)
    ) u_walker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tuser),
        .in_req        (s_tdata[SIZE_W-1:0]),
        .in_addr       (s_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
        .first_address (first_address_reg),
        .block_bytes   (block_bytes_reg),
        .out_free      (out_free),
        .res           (res),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data)
    );

    fba_flag_ram #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .IDX_W       (IDX_W)
    ) u_flag_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

@@ hdl/fba_checker.sv @@
// ----------------------------------------------------------------------------
// Fixed block allocator port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_block_allocator_unit_defines.svh"

module fba_checker
    import fba_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [ADDR_W-1:0]   m_tdata,
    input logic [STATUS_W-1:0] m_tuser
);

    // A stalled result transfer holds its payload
    `FBA_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Only defined status codes
    `FBA_ASSERT(a_status_code, aclk, aresetn, m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NO_BLOCK || m_tuser == ST_NO_MATCH), "undefined status code")

    // Failed requests carry a zero address
    `FBA_ASSERT(a_fail_zero, aclk, aresetn, m_tvalid && m_tuser != ST_OK |-> m_tdata == '0, "nonzero address on error")

    // A taken request holds off the next one in the cycle after it is taken
    `FBA_ASSERT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "request taken while another is in progress")

    // Reset starts the clearing pass with requests held off
    `FBA_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !s_tready, "request accepted during memory clear")

endmodule

bind fixed_block_allocator_unit fba_checker u_fba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
